// File: rtl/hsv2rgb_pkg.sv
// shared types and constants for the hsv to rgb converter
// no dependencies; used by hsv2rgb_levels and hsv_to_rgb_unit
package hsv2rgb_pkg;

	localparam logic [16:0] FIX_ONE    = 17'd65536;
	localparam logic [14:0] HUE_TURN   = 15'd23040;
	localparam logic [11:0] HUE_SECTOR = 12'd3840;
	// one in q1.16 times one sector
	localparam logic [27:0] HUE_BIG    = 28'd251658240;
	localparam logic [7:0]  LEVEL_MAX  = 8'd255;

	typedef enum logic [2:0] {
		SEC_RY,
		SEC_YG,
		SEC_GC,
		SEC_CB,
		SEC_BM,
		SEC_MR
	} sector_t;

	typedef struct packed {
		logic [14:0] hue;
		logic [16:0] saturation;
		logic [16:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// after hue split and clamping
	typedef struct packed {
		sector_t     sector;
		logic [11:0] rem;
		logic [16:0] sat;
		logic [16:0] val;
	} stage1_t;

	// one minus s, and the q and t factors scaled by one sector
	typedef struct packed {
		sector_t     sector;
		logic [16:0] val;
		logic [16:0] oms;
		logic [27:0] lq;
		logic [27:0] lt;
	} stage2_t;

	// levels times value
	typedef struct packed {
		sector_t     sector;
		logic [33:0] pv;
		logic [44:0] qv;
		logic [44:0] tv;
		logic [24:0] vv;
	} stage3_t;

endpackage

// File: rtl/hsv2rgb_levels.sv
// multiplier stages of the hsv to rgb converter: forms p, q, t and v products
// depends on hsv2rgb_pkg
module hsv2rgb_levels (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_in,
	input  hsv2rgb_pkg::stage1_t  data_in,
	output logic                  vld_out,
	output hsv2rgb_pkg::stage3_t  data_out
);

	logic                 vld_s2;
	logic                 vld_s3;
	hsv2rgb_pkg::stage2_t data_s2;
	hsv2rgb_pkg::stage3_t data_s3;

	logic [28:0] sr;
	logic [28:0] st;
	logic [11:0] rc;

	assign rc = hsv2rgb_pkg::HUE_SECTOR - data_in.rem;
	assign sr = {12'd0, data_in.sat} * {17'd0, data_in.rem};
	assign st = {12'd0, data_in.sat} * {17'd0, rc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_in;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		data_s2.sector <= data_in.sector;
		data_s2.val    <= data_in.val;
		data_s2.oms    <= hsv2rgb_pkg::FIX_ONE - data_in.sat;
		// products never exceed one sector's worth, so the top bit drops
		data_s2.lq     <= 28'({1'b0, hsv2rgb_pkg::HUE_BIG} - sr);
		data_s2.lt     <= 28'({1'b0, hsv2rgb_pkg::HUE_BIG} - st);

		data_s3.sector <= data_s2.sector;
		data_s3.pv     <= {17'd0, data_s2.val} * {17'd0, data_s2.oms};
		data_s3.qv     <= {28'd0, data_s2.val} * {17'd0, data_s2.lq};
		data_s3.tv     <= {28'd0, data_s2.val} * {17'd0, data_s2.lt};
		data_s3.vv     <= {8'd0, data_s2.val} * {17'd0, hsv2rgb_pkg::LEVEL_MAX};
	end

	assign vld_out  = vld_s3;
	assign data_out = data_s3;

endmodule

// File: rtl/hsv_to_rgb_unit.sv
// each request is registered in stage s1, in stages s2 and s3 of hsv2rgb_levels, and in s4 before done
// throughput: one request per cycle; busy stays low, the four-stage pipeline never stalls
// each result is shown with done for one cycle and is not held
// reset clears only the stage valid bits; data registers are not reset
// depends on hsv2rgb_pkg and hsv2rgb_levels
module hsv_to_rgb_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hsv2rgb_pkg::hsv_t request,
	output logic              done,
	output hsv2rgb_pkg::rgb_t result
);

	logic                 vld_s1;
	hsv2rgb_pkg::stage1_t data_s1;
	logic                 vld_s3;
	hsv2rgb_pkg::stage3_t data_s3;
	logic                 vld_s4;
	hsv2rgb_pkg::rgb_t    result_s4;

	logic [14:0]          h_eff;
	logic [14:0]          h_base;
	hsv2rgb_pkg::sector_t sec;
	logic [16:0]          s_cl;
	logic [16:0]          v_cl;

	logic [41:0] p255;
	logic [49:0] q17;
	logic [49:0] t17;
	logic [7:0]  pch;
	logic [7:0]  qch;
	logic [7:0]  tch;
	logic [7:0]  vch;
	hsv2rgb_pkg::rgb_t rgb_next;

	assign busy = 1'b0;

	// hue split into sector and remainder; hue out of range maps to zero, saturation and brightness clamp to one
	always_comb begin
		h_eff = (request.hue >= hsv2rgb_pkg::HUE_TURN) ? 15'd0 : request.hue;
		if (h_eff >= 15'd19200) begin
			sec    = hsv2rgb_pkg::SEC_MR;
			h_base = 15'd19200;
		end else if (h_eff >= 15'd15360) begin
			sec    = hsv2rgb_pkg::SEC_BM;
			h_base = 15'd15360;
		end else if (h_eff >= 15'd11520) begin
			sec    = hsv2rgb_pkg::SEC_CB;
			h_base = 15'd11520;
		end else if (h_eff >= 15'd7680) begin
			sec    = hsv2rgb_pkg::SEC_GC;
			h_base = 15'd7680;
		end else if (h_eff >= 15'd3840) begin
			sec    = hsv2rgb_pkg::SEC_YG;
			h_base = 15'd3840;
		end else begin
			sec    = hsv2rgb_pkg::SEC_RY;
			h_base = 15'd0;
		end
		s_cl = (request.saturation > hsv2rgb_pkg::FIX_ONE) ?
			hsv2rgb_pkg::FIX_ONE : request.saturation;
		v_cl = (request.brightness > hsv2rgb_pkg::FIX_ONE) ?
			hsv2rgb_pkg::FIX_ONE : request.brightness;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.sector <= sec;
		data_s1.rem    <= 12'(h_eff - h_base);
		data_s1.sat    <= s_cl;
		data_s1.val    <= v_cl;
		result_s4      <= rgb_next;
	end

	hsv2rgb_levels u_levels (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s1),
		.data_in  (data_s1),
		.vld_out  (vld_s3),
		.data_out (data_s3)
	);

	// the factor 15 of 3840 cancels against 255, leaving times 17 over 2^40
	assign p255 = {data_s3.pv, 8'd0} - {8'd0, data_s3.pv};
	assign q17  = {1'b0, data_s3.qv, 4'd0} + {5'd0, data_s3.qv};
	assign t17  = {1'b0, data_s3.tv, 4'd0} + {5'd0, data_s3.tv};
	assign pch  = p255[39:32];
	assign qch  = q17[47:40];
	assign tch  = t17[47:40];
	assign vch  = data_s3.vv[23:16];

	always_comb begin
		case (data_s3.sector)
			hsv2rgb_pkg::SEC_RY: rgb_next = '{red: vch, green: tch, blue: pch};
			hsv2rgb_pkg::SEC_YG: rgb_next = '{red: qch, green: vch, blue: pch};
			hsv2rgb_pkg::SEC_GC: rgb_next = '{red: pch, green: vch, blue: tch};
			hsv2rgb_pkg::SEC_CB: rgb_next = '{red: pch, green: qch, blue: vch};
			hsv2rgb_pkg::SEC_BM: rgb_next = '{red: tch, green: pch, blue: vch};
			default:             rgb_next = '{red: vch, green: pch, blue: qch};
		endcase
	end

	assign done   = vld_s4;
	assign result = result_s4;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("request did not produce a result after four cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s3))
		else $error("result strobe without a product stage behind it");

	a_level_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (pch <= qch && pch <= tch && qch <= vch && tch <= vch))
		else $error("channel levels out of order");
`endif

endmodule
